// File: design/sbsm_pkg.sv
// ----------------------------------------------------------------------------
// sbsm_pkg: shared types and constants of the serial bank switch mapper
// Holds the mapper state word, the result word and the codes that the
// top level and the update logic both use.
// ----------------------------------------------------------------------------
package sbsm_pkg;

	// largest block counts the board can carry
	localparam logic [4:0] MAX_PRG_BLOCKS = 5'd16;
	localparam logic [5:0] MAX_CHR_BLOCKS = 6'd32;

	// configuration register indexes
	localparam logic [1:0] CFG_MAPPER_KIND = 2'd0;
	localparam logic [1:0] CFG_PRG_COUNT   = 2'd1;
	localparam logic [1:0] CFG_CHR_COUNT   = 2'd2;

	// mapper kinds
	localparam logic [1:0] KIND_FIXED  = 2'd0;
	localparam logic [1:0] KIND_SERIAL = 2'd1;
	localparam logic [1:0] KIND_DIRECT = 2'd2;

	// serial register selects from address bits 14..13
	localparam logic [1:0] SEL_CONTROL = 2'd0;
	localparam logic [1:0] SEL_CHR0    = 2'd1;
	localparam logic [1:0] SEL_CHR1    = 2'd2;
	localparam logic [1:0] SEL_PRG     = 2'd3;

	// program bank modes
	localparam logic [1:0] PRG_MODE_32K     = 2'd0;
	localparam logic [1:0] PRG_MODE_32K_ALT = 2'd1;
	localparam logic [1:0] PRG_MODE_FIX_LOW = 2'd2;

	// serial shifter completes on the fifth bit
	localparam logic [2:0] SHIFT_LAST = 3'd4;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic [4:0] shift_value;
		logic [2:0] shift_count;
		logic       chr_half_mode;
		logic [1:0] prg_mode;
		logic [3:0] low_bank;
		logic [3:0] high_bank;
		logic [5:0] low_chr;
		logic [5:0] high_chr;
		logic [1:0] mirror;
	} map_state_t;

	typedef struct packed {
		logic [17:0] rom_address;
		logic        rom_hit;
		logic [3:0]  low_prg_bank;
		logic [3:0]  high_prg_bank;
		logic [5:0]  low_chr_half;
		logic [5:0]  high_chr_half;
		logic [1:0]  mirror_mode;
		logic        write_ignored;
	} map_result_t;

	localparam map_state_t STATE_RESET = '{
		shift_value:   5'd0,
		shift_count:   3'd0,
		chr_half_mode: 1'b0,
		prg_mode:      PRG_MODE_32K,
		low_bank:      4'd0,
		high_bank:     4'd1,
		low_chr:       6'd0,
		high_chr:      6'd1,
		mirror:        2'd0
	};

endpackage

// File: design/sbsm_update.sv
// ----------------------------------------------------------------------------
// sbsm_update: next state and result for one bus access
// Translates reads into program ROM addresses and applies writes to the
// serial or direct mapper, checking bank selects against the block counts.
// ----------------------------------------------------------------------------
module sbsm_update (
	input  logic [1:0]           kind,
	input  logic [4:0]           prg_count,
	input  logic [5:0]           chr_count,
	input  sbsm_pkg::map_state_t cur,
	input  logic                 op,
	input  logic [15:0]          address,
	input  logic [7:0]           value,
	output sbsm_pkg::map_state_t nxt,
	output sbsm_pkg::map_result_t res
);

	logic [4:0] pc;
	logic [5:0] cc;
	logic       ignored_w;

	// block counts saturate at the board maximum
	assign pc = (prg_count > sbsm_pkg::MAX_PRG_BLOCKS) ? sbsm_pkg::MAX_PRG_BLOCKS : prg_count;
	assign cc = (chr_count > sbsm_pkg::MAX_CHR_BLOCKS) ? sbsm_pkg::MAX_CHR_BLOCKS : chr_count;

	// state update and drop flag
	always_comb begin
		logic [4:0] v;
		logic [3:0] pair_low;
		logic [3:0] pair_high;
		logic [4:0] pc_m1;

		nxt       = cur;
		ignored_w = 1'b0;
		v         = {value[0], cur.shift_value[4:1]};
		pair_low  = {v[3:1], 1'b0};
		pair_high = {v[3:1], 1'b1};
		pc_m1     = pc - 5'd1;

		if (op == sbsm_pkg::OP_WRITE && address[15]) begin
			priority if (kind == sbsm_pkg::KIND_SERIAL) begin
				if (value[7]) begin
					nxt.shift_value = 5'd0;
					nxt.shift_count = 3'd0;
				end else if (cur.shift_count >= sbsm_pkg::SHIFT_LAST) begin
					// fifth bit: commit to the register picked by the address
					nxt.shift_value = 5'd0;
					nxt.shift_count = 3'd0;
					unique case (address[14:13])
						sbsm_pkg::SEL_CONTROL: begin
							nxt.mirror        = v[1:0];
							nxt.prg_mode      = (v[3:2] == sbsm_pkg::PRG_MODE_32K_ALT) ?
								sbsm_pkg::PRG_MODE_32K : v[3:2];
							nxt.chr_half_mode = v[4];
						end
						sbsm_pkg::SEL_CHR0: begin
							if ({2'b00, v[4:1]} >= cc) begin
								ignored_w = 1'b1;
							end else if (!cur.chr_half_mode) begin
								nxt.low_chr  = {1'b0, v[4:1], 1'b0};
								nxt.high_chr = {1'b0, v[4:1], 1'b1};
							end else begin
								nxt.low_chr = {1'b0, v};
							end
						end
						sbsm_pkg::SEL_CHR1: begin
							if (cur.chr_half_mode) begin
								if ({2'b00, v[4:1]} >= cc) begin
									ignored_w = 1'b1;
								end else begin
									nxt.high_chr = {1'b0, v};
								end
							end
						end
						sbsm_pkg::SEL_PRG: begin
							if (cur.prg_mode == sbsm_pkg::PRG_MODE_32K) begin
								if ({1'b0, pair_high} >= pc) begin
									ignored_w = 1'b1;
								end else begin
									nxt.low_bank  = pair_low;
									nxt.high_bank = pair_high;
								end
							end else if ({1'b0, v[3:0]} >= pc) begin
								ignored_w = 1'b1;
							end else if (cur.prg_mode == sbsm_pkg::PRG_MODE_FIX_LOW) begin
								nxt.low_bank  = 4'd0;
								nxt.high_bank = v[3:0];
							end else begin
								nxt.low_bank  = v[3:0];
								nxt.high_bank = pc_m1[3:0];
							end
						end
						default: begin
							nxt = cur;
						end
					endcase
				end else begin
					nxt.shift_value = v;
					nxt.shift_count = cur.shift_count + 3'd1;
				end
			end else if (kind == sbsm_pkg::KIND_DIRECT) begin
				// 8 KB character block straight from the data byte
				if (value < {2'b00, cc}) begin
					nxt.low_chr  = {value[4:0], 1'b0};
					nxt.high_chr = {value[4:0], 1'b1};
				end else begin
					ignored_w = 1'b1;
				end
			end else begin
				nxt = cur;
			end
		end
	end

	// read translation and visible bank state
	always_comb begin
		logic [3:0] bank;

		bank            = address[14] ? cur.high_bank : cur.low_bank;
		res.rom_hit     = (op == sbsm_pkg::OP_READ) && address[15];
		res.rom_address = res.rom_hit ? {bank, address[13:0]} : 18'd0;
		res.low_prg_bank  = nxt.low_bank;
		res.high_prg_bank = nxt.high_bank;
		res.low_chr_half  = nxt.low_chr;
		res.high_chr_half = nxt.high_chr;
		res.mirror_mode   = nxt.mirror;
		res.write_ignored = ignored_w;
	end

endmodule

// File: design/serial_bank_switch_mapper.sv
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper: cartridge program and character bank mapper
// Input register, single-pass update logic and a result register.
// ----------------------------------------------------------------------------
// One bus access is accepted per cycle while in_stall is low; its result
// word passes the input register, then the result register. The mapper
// state is updated as the word moves from the input register into the
// result register, so every access sees all earlier ones. out_stall reaches
// in_stall combinationally; a held result stops the input register only
// when that register is full. Configuration registers come out of reset as
// fixed banks, two program blocks and one character block; the user must
// write them only while no word is in flight, the block does not enforce it.
module serial_bank_switch_mapper (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	// access channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [15:0] address,
	input  logic [7:0]  value,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [17:0] rom_address,
	output logic        rom_hit,
	output logic [3:0]  low_prg_bank,
	output logic [3:0]  high_prg_bank,
	output logic [5:0]  low_chr_half,
	output logic [5:0]  high_chr_half,
	output logic [1:0]  mirror_mode,
	output logic        write_ignored
);

	logic [1:0]  kind_q;
	logic [4:0]  prg_count_q;
	logic [5:0]  chr_count_q;
	sbsm_pkg::map_state_t  state_q;
	sbsm_pkg::map_state_t  state_nxt;
	sbsm_pkg::map_result_t res_nxt;
	sbsm_pkg::map_result_t result_q;

	logic        valid_s1;
	logic        op_s1;
	logic [15:0] address_s1;
	logic [7:0]  value_s1;
	logic        out_valid_q;
	logic        out_free;
	logic        advance;
	logic        in_accept;

	// handshake
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= sbsm_pkg::KIND_FIXED;
			prg_count_q <= 5'd2;
			chr_count_q <= 6'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbsm_pkg::CFG_MAPPER_KIND: kind_q      <= cfg_data[1:0];
				sbsm_pkg::CFG_PRG_COUNT:   prg_count_q <= cfg_data[4:0];
				sbsm_pkg::CFG_CHR_COUNT:   chr_count_q <= cfg_data;
				default:                   kind_q      <= kind_q;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1      <= op;
			address_s1 <= address;
			value_s1   <= value;
		end
	end

	sbsm_update u_update (
		.kind      (kind_q),
		.prg_count (prg_count_q),
		.chr_count (chr_count_q),
		.cur       (state_q),
		.op        (op_s1),
		.address   (address_s1),
		.value     (value_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// mapper state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbsm_pkg::STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign rom_address   = result_q.rom_address;
	assign rom_hit       = result_q.rom_hit;
	assign low_prg_bank  = result_q.low_prg_bank;
	assign high_prg_bank = result_q.high_prg_bank;
	assign low_chr_half  = result_q.low_chr_half;
	assign high_chr_half = result_q.high_chr_half;
	assign mirror_mode   = result_q.mirror_mode;
	assign write_ignored = result_q.write_ignored;

	// shifter never holds more than four pending bits
	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.shift_count <= sbsm_pkg::SHIFT_LAST)
		else $error("shift count overflow");

	// a read leaves the mapper state untouched
	a_read_stable: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (op_s1 == sbsm_pkg::OP_READ) |=> $stable(state_q))
		else $error("read changed mapper state");

	// a translated read uses one of the reported program banks
	a_hit_bank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.rom_hit |->
		(result_q.rom_address[17:14] == result_q.low_prg_bank) ||
		(result_q.rom_address[17:14] == result_q.high_prg_bank))
		else $error("read translated through unknown bank");

	// a word is never both a read hit and a dropped write
	a_hit_or_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(result_q.rom_hit && result_q.write_ignored))
		else $error("read flagged as dropped write");

endmodule

// File: test/tb_serial_bank_switch_mapper.sv
// ----------------------------------------------------------------------------
// tb_serial_bank_switch_mapper: self-checking bench for the bank mapper
// Drives CPU bus words through the valid/stall access channel, predicts every
// result word with a behavioral copy of the mapper and compares field by
// field. Runs directed words, then random phases under several settings of
// mapper kind and block counts, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_serial_bank_switch_mapper;

	// spare mapper kind, behaves as fixed banks
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_WORDS = 52;

	// behavioral mapper and store of expected result words
	class bank_scoreboard;
		sbsm_pkg::map_state_t  st;
		logic [1:0]  kind;
		logic [4:0]  prg_blocks;
		logic [5:0]  chr_blocks;
		sbsm_pkg::map_result_t expected_q[$];
		int errors, accesses, results, rom_reads, commits, dropped;

		function new();
			st = sbsm_pkg::STATE_RESET;
			kind = sbsm_pkg::KIND_FIXED;
			prg_blocks = 5'd2;
			chr_blocks = 6'd1;
		endfunction

		function void set_reg(logic [1:0] idx, logic [5:0] data);
			case (idx)
				sbsm_pkg::CFG_MAPPER_KIND: kind = data[1:0];
				sbsm_pkg::CFG_PRG_COUNT:   prg_blocks = data[4:0];
				sbsm_pkg::CFG_CHR_COUNT:   chr_blocks = data;
				default: ;
			endcase
		endfunction

		// completed five-bit value into the selected register, 1 if dropped
		function bit commit_serial(logic [1:0] sel, logic [4:0] v);
			int pc;
			int cc;
			pc = (prg_blocks > sbsm_pkg::MAX_PRG_BLOCKS) ?
				int'(sbsm_pkg::MAX_PRG_BLOCKS) : int'(prg_blocks);
			cc = (chr_blocks > sbsm_pkg::MAX_CHR_BLOCKS) ?
				int'(sbsm_pkg::MAX_CHR_BLOCKS) : int'(chr_blocks);
			case (sel)
				sbsm_pkg::SEL_CONTROL: begin
					st.mirror = v[1:0];
					st.prg_mode = (v[3:2] == sbsm_pkg::PRG_MODE_32K_ALT) ?
						sbsm_pkg::PRG_MODE_32K : v[3:2];
					st.chr_half_mode = v[4];
				end
				sbsm_pkg::SEL_CHR0: begin
					if (int'(v[4:1]) >= cc)
						return 1'b1;
					if (!st.chr_half_mode) begin
						st.low_chr = {1'b0, v[4:1], 1'b0};
						st.high_chr = {1'b0, v[4:1], 1'b1};
					end else begin
						st.low_chr = {1'b0, v};
					end
				end
				sbsm_pkg::SEL_CHR1: begin
					// no effect in 8 KB mode
					if (st.chr_half_mode) begin
						if (int'(v[4:1]) >= cc)
							return 1'b1;
						st.high_chr = {1'b0, v};
					end
				end
				default: begin
					case (st.prg_mode)
						sbsm_pkg::PRG_MODE_32K: begin
							if (int'({v[3:1], 1'b1}) >= pc)
								return 1'b1;
							st.low_bank = {v[3:1], 1'b0};
							st.high_bank = {v[3:1], 1'b1};
						end
						sbsm_pkg::PRG_MODE_FIX_LOW: begin
							if (int'(v[3:0]) >= pc)
								return 1'b1;
							st.low_bank = 4'd0;
							st.high_bank = v[3:0];
						end
						default: begin
							// last block fixed at 0xC000
							if (int'(v[3:0]) >= pc)
								return 1'b1;
							st.low_bank = v[3:0];
							st.high_bank = 4'(pc - 1);
						end
					endcase
				end
			endcase
			return 1'b0;
		endfunction

		// accepted access word: update state and queue the expected result
		function void note_access(logic o, logic [15:0] a, logic [7:0] v);
			sbsm_pkg::map_result_t r;
			int cc;
			r = '0;
			accesses++;
			cc = (chr_blocks > sbsm_pkg::MAX_CHR_BLOCKS) ?
				int'(sbsm_pkg::MAX_CHR_BLOCKS) : int'(chr_blocks);
			if (o == sbsm_pkg::OP_READ) begin
				if (a[15]) begin
					r.rom_hit = 1'b1;
					r.rom_address = {(a[14] ? st.high_bank : st.low_bank), a[13:0]};
					rom_reads++;
				end
			end else if (a[15]) begin
				if (kind == sbsm_pkg::KIND_SERIAL) begin
					if (v[7]) begin
						st.shift_value = '0;
						st.shift_count = '0;
					end else begin
						st.shift_value = {v[0], st.shift_value[4:1]};
						st.shift_count = st.shift_count + 3'd1;
						if (st.shift_count > sbsm_pkg::SHIFT_LAST) begin
							r.write_ignored = commit_serial(a[14:13], st.shift_value);
							commits++;
							st.shift_value = '0;
							st.shift_count = '0;
						end
					end
				end else if (kind == sbsm_pkg::KIND_DIRECT) begin
					if (int'(v) < cc) begin
						st.low_chr = {v[4:0], 1'b0};
						st.high_chr = {v[4:0], 1'b1};
					end else begin
						r.write_ignored = 1'b1;
					end
				end
			end
			r.low_prg_bank = st.low_bank;
			r.high_prg_bank = st.high_bank;
			r.low_chr_half = st.low_chr;
			r.high_chr_half = st.high_chr;
			r.mirror_mode = st.mirror;
			if (r.write_ignored)
				dropped++;
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [17:0] want_v, logic [17:0] got_v);
			if (got_v !== want_v) begin
				$error("%s: expected %0d, got %0d", name, want_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(sbsm_pkg::map_result_t got);
			sbsm_pkg::map_result_t want;
			results++;
			if (expected_q.size() == 0) begin
				$error("result word with no access pending");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("rom_address", want.rom_address, got.rom_address);
			compare_field("rom_hit", 18'(want.rom_hit), 18'(got.rom_hit));
			compare_field("low_prg_bank", 18'(want.low_prg_bank), 18'(got.low_prg_bank));
			compare_field("high_prg_bank", 18'(want.high_prg_bank), 18'(got.high_prg_bank));
			compare_field("low_chr_half", 18'(want.low_chr_half), 18'(got.low_chr_half));
			compare_field("high_chr_half", 18'(want.high_chr_half), 18'(got.high_chr_half));
			compare_field("mirror_mode", 18'(want.mirror_mode), 18'(got.mirror_mode));
			compare_field("write_ignored", 18'(want.write_ignored), 18'(got.write_ignored));
		endfunction

		function void close_out();
			if (expected_q.size() != 0) begin
				$error("%0d expected result words never arrived", expected_q.size());
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [5:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [15:0] address;
	logic [7:0]  value;
	logic        out_valid;
	logic        out_stall;
	logic [17:0] rom_address;
	logic        rom_hit;
	logic [3:0]  low_prg_bank;
	logic [3:0]  high_prg_bank;
	logic [5:0]  low_chr_half;
	logic [5:0]  high_chr_half;
	logic [1:0]  mirror_mode;
	logic        write_ignored;

	bank_scoreboard sb;
	bit idle_off;
	int sent;
	int settings_run;
	int idle_cycles;

	serial_bank_switch_mapper uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.address(address),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.rom_address(rom_address),
		.rom_hit(rom_hit),
		.low_prg_bank(low_prg_bank),
		.high_prg_bank(high_prg_bank),
		.low_chr_half(low_chr_half),
		.high_chr_half(high_chr_half),
		.mirror_mode(mirror_mode),
		.write_ignored(write_ignored)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (idle_off || r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// one access word, held until accepted
	task automatic send(input logic o, input logic [15:0] a, input logic [7:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		address <= a;
		value <= v;
		do @(posedge clk); while (in_stall);
		sb.note_access(o, a, v);
		sent++;
	endtask

	task automatic send_noise();
		send(1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom));
	endtask

	// five serial writes, lsb first, the last address picks the register
	task automatic serial_load(input logic [15:0] a, input logic [4:0] v);
		for (int i = 0; i < 5; i++)
			send(sbsm_pkg::OP_WRITE, a, {1'b0, 6'($urandom), v[i]});
	endtask

	// sender holds off until every expected word has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
	endtask

	task automatic set_config(input logic [1:0] kind, input logic [4:0] prg_n,
			input logic [5:0] chr_n);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= sbsm_pkg::CFG_MAPPER_KIND;
		cfg_data <= {4'b0000, kind};
		@(posedge clk);
		sb.set_reg(sbsm_pkg::CFG_MAPPER_KIND, {4'b0000, kind});
		cfg_index <= sbsm_pkg::CFG_PRG_COUNT;
		cfg_data <= {1'b0, prg_n};
		@(posedge clk);
		sb.set_reg(sbsm_pkg::CFG_PRG_COUNT, {1'b0, prg_n});
		cfg_index <= sbsm_pkg::CFG_CHR_COUNT;
		cfg_data <= chr_n;
		@(posedge clk);
		sb.set_reg(sbsm_pkg::CFG_CHR_COUNT, chr_n);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// serial mapper traffic: mostly full sequences, some broken, some noise
	task automatic serial_traffic();
		int pick;
		logic [1:0] sel;
		logic [4:0] v;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			sel = 2'($urandom);
			v = 5'($urandom);
			for (int i = 0; i < 5; i++) begin
				// reads and low writes between bits leave the shifter alone
				if ($urandom_range(0, 7) == 0) begin
					if ($urandom_range(0, 1) == 0)
						send(sbsm_pkg::OP_READ, 16'($urandom), 8'($urandom));
					else
						send(sbsm_pkg::OP_WRITE, {1'b0, 15'($urandom)}, 8'($urandom));
				end
				// broken sequence, shifter cleared midway
				if (i > 0 && $urandom_range(0, 39) == 0) begin
					send(sbsm_pkg::OP_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
					break;
				end
				if (i == 4)
					send(sbsm_pkg::OP_WRITE, {1'b1, sel, 13'($urandom)},
						{1'b0, 6'($urandom), v[i]});
				else
					send(sbsm_pkg::OP_WRITE, {1'b1, 15'($urandom)},
						{1'b0, 6'($urandom), v[i]});
			end
		end else if (pick < 75) begin
			send(sbsm_pkg::OP_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
		end else if (pick < 88) begin
			send(sbsm_pkg::OP_READ, {1'b1, 15'($urandom)}, 8'($urandom));
		end else begin
			send_noise();
		end
	endtask

	// direct mapper traffic: mostly small character selects
	task automatic direct_traffic();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			send(sbsm_pkg::OP_WRITE, {1'b1, 15'($urandom)},
				($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40)));
		else if (pick < 80)
			send(sbsm_pkg::OP_READ, {1'b1, 15'($urandom)}, 8'($urandom));
		else
			send_noise();
	endtask

	task automatic run_phase(input logic [1:0] kind, input logic [4:0] prg_n,
			input logic [5:0] chr_n, input bit calm);
		int start;
		set_config(kind, prg_n, chr_n);
		idle_off = calm;
		start = sent;
		while (sent - start < PHASE_WORDS) begin
			if (kind == sbsm_pkg::KIND_SERIAL)
				serial_traffic();
			else if (kind == sbsm_pkg::KIND_DIRECT)
				direct_traffic();
			else
				send_noise();
		end
		idle_off = 1'b0;
	endtask

	// result side: random stalls, check each accepted word
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result({rom_address, rom_hit, low_prg_bank, high_prg_bank,
					low_chr_half, high_chr_half, mirror_mode, write_ignored});
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (!idle_off && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// stimulus
	initial begin
		sb = new();
		idle_off = 1'b0;
		sent = 0;
		settings_run = 1;
		idle_cycles = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= sbsm_pkg::CFG_MAPPER_KIND;
		cfg_data <= '0;
		in_valid <= 1'b0;
		op <= sbsm_pkg::OP_WRITE;
		address <= '0;
		value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: fixed banks, reads below ROM, at both edges of the low bank and at the top of the high bank
		send(sbsm_pkg::OP_READ, 16'h0000, 8'hFF);
		send(sbsm_pkg::OP_READ, 16'h8000, 8'h00);
		send(sbsm_pkg::OP_READ, 16'hBFFF, 8'h00);
		send(sbsm_pkg::OP_READ, 16'hFFFF, 8'h00);
		send(sbsm_pkg::OP_WRITE, 16'h8000, 8'h01);

		// serial mapper, largest counts
		set_config(sbsm_pkg::KIND_SERIAL, 5'd16, 6'd32);
		send(sbsm_pkg::OP_WRITE, 16'h8000, 8'hFF);
		// control: 4 KB characters, program mode 1 taken as 32 KB, vertical
		serial_load(16'h8000, 5'b10110);
		send(sbsm_pkg::OP_WRITE, 16'h7FFF, 8'h01);
		serial_load(16'hE000, 5'h1F);
		serial_load(16'hA000, 5'h1F);
		send(sbsm_pkg::OP_READ, 16'hC123, 8'h00);

		// random phases over the settings, extremes included
		run_phase(sbsm_pkg::KIND_SERIAL, 5'd16, 6'd32, 1'b0);
		run_phase(sbsm_pkg::KIND_SERIAL, 5'd1, 6'd1, 1'b0);
		run_phase(sbsm_pkg::KIND_SERIAL, 5'd31, 6'd63, 1'b1);
		run_phase(sbsm_pkg::KIND_DIRECT, 5'd4, 6'd63, 1'b0);
		run_phase(sbsm_pkg::KIND_DIRECT, 5'd16, 6'd1, 1'b0);
		run_phase(sbsm_pkg::KIND_FIXED, 5'd2, 6'd1, 1'b0);
		run_phase(KIND_SPARE, 5'd31, 6'd63, 1'b0);
		run_phase(sbsm_pkg::KIND_SERIAL, 5'd3, 6'd5, 1'b0);
		run_phase(sbsm_pkg::KIND_SERIAL, 5'($urandom_range(1, 31)),
			6'($urandom_range(1, 63)), 1'b0);
		run_phase(sbsm_pkg::KIND_DIRECT, 5'($urandom_range(1, 31)),
			6'($urandom_range(1, 63)), 1'b0);
		run_phase(sbsm_pkg::KIND_SERIAL, 5'd8, 6'd16, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		sb.close_out();

		$display("ran %0d access words and checked %0d result words over %0d settings",
			sb.accesses, sb.results, settings_run);
		$display("%0d rom reads translated, %0d serial commits, %0d dropped selects",
			sb.rom_reads, sb.commits, sb.dropped);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
design/sbsm_pkg.sv
design/sbsm_update.sv
design/serial_bank_switch_mapper.sv
test/tb_serial_bank_switch_mapper.sv
